/* rtl/jshs_pkg.sv */
// shared types, codes and constants for the joystick stepper half-step driver
package jshs_pkg;

   // widths of the item fields
   localparam int unsigned JOY_W   = 10;
   localparam int unsigned SPEED_W = 9;
   localparam int unsigned TICK_W  = 6;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned COIL_W  = 4;
   localparam int unsigned CSR_W   = 9;

   // stream data widths, padded to whole bytes
   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 24;

   // register indexes on the csr port
   localparam logic CSR_STICK_THRESHOLD = 1'b0;
   localparam logic CSR_SLOWEST_SETTING = 1'b1;

   // register reset values
   localparam logic [CSR_W-1:0] THRESHOLD_RESET = 9'd200;
   localparam logic [CSR_W-1:0] SLOWEST_RESET   = 9'd500;

   // axis full scale used for the high-side deflection test
   localparam logic [JOY_W-1:0] AXIS_TOP = 10'd1000;

   // step interval = (setting-1)*39/500 + 1
   // floor(p/500) for p below 59075 equals (p*33555) >> 24, folded with the 39
   localparam logic [20:0] INTERVAL_MULT  = 21'd1308645;
   localparam int unsigned INTERVAL_SHIFT = 24;

   localparam logic [TICK_W-1:0] TICK_MAX = 6'd63;

   typedef enum logic [1:0] {
      MODE_CCW  = 2'd0,
      MODE_CW   = 2'd1,
      MODE_STOP = 2'd2,
      MODE_INIT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STICK_OFF     = 3'd0,
      STICK_PRESSED = 3'd1,
      STICK_UP      = 3'd2,
      STICK_DOWN    = 3'd3,
      STICK_RIGHT   = 3'd4,
      STICK_LEFT    = 3'd5
   } stick_type;

   // input item, joy_x in the lowest bits
   typedef struct packed {
      logic             button_n;
      logic [JOY_W-1:0] joy_y;
      logic [JOY_W-1:0] joy_x;
   } req_type;

   // result item, coils in the lowest bits
   typedef struct packed {
      stick_type          stick_status;
      logic [SPEED_W-1:0] speed_setting;
      mode_type           motor_mode;
      logic               stepped;
      logic [COIL_W-1:0]  coils;
   } rsp_type;

   // half-step coil pattern for a phase index
   function automatic logic [COIL_W-1:0] half_step(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pat;
      begin
         case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
         endcase
         return pat;
      end
   endfunction

endpackage

/* rtl/jshs_classify.sv */
// joystick classifier: turns the axis readings and button into one stick status
module jshs_classify (
   input  jshs_pkg::req_type            item,
   input  logic [jshs_pkg::CSR_W-1:0]   threshold,
   output jshs_pkg::stick_type          status
);

   logic [jshs_pkg::JOY_W-1:0] thr_ext;
   logic [jshs_pkg::JOY_W-1:0] hi_mark;

   assign thr_ext = {1'b0, threshold};
   assign hi_mark = jshs_pkg::AXIS_TOP - thr_ext;

   // priority: right, left, up, down, pressed, off
   always_comb begin
      if (item.joy_y >= hi_mark) begin
         status = jshs_pkg::STICK_RIGHT;
      end else if (item.joy_y <= thr_ext) begin
         status = jshs_pkg::STICK_LEFT;
      end else if (item.joy_x >= hi_mark) begin
         status = jshs_pkg::STICK_UP;
      end else if (item.joy_x <= thr_ext) begin
         status = jshs_pkg::STICK_DOWN;
      end else if (!item.button_n) begin
         status = jshs_pkg::STICK_PRESSED;
      end else begin
         status = jshs_pkg::STICK_OFF;
      end
   end

endmodule

/* rtl/jshs_ctrl.sv */
// mode machine, speed setting, tick counter and half-step phase sequencer
module jshs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  jshs_pkg::stick_type           status,
   input  logic [jshs_pkg::CSR_W-1:0]    slowest,
   output jshs_pkg::rsp_type             result
);

   jshs_pkg::mode_type                  mode_ff, mode_in, mode_next;
   logic [jshs_pkg::SPEED_W-1:0]        speed_ff, speed_in, speed_next;
   logic [jshs_pkg::PHASE_W-1:0]        phase_ff, phase_in;
   logic                                last_cw_ff, last_cw_in;
   logic [jshs_pkg::TICK_W-1:0]         ticks_ff, ticks_in;
   logic [jshs_pkg::COIL_W-1:0]         coil_ff, coil_in;

   logic [jshs_pkg::SPEED_W-1:0]        limit;
   logic [jshs_pkg::SPEED_W:0]          speed_up1;
   logic [jshs_pkg::SPEED_W-1:0]        speed_m1;
   logic [29:0]                         interval_prod;
   logic [jshs_pkg::TICK_W-1:0]         interval;
   logic [jshs_pkg::TICK_W-1:0]         ticks_inc;
   logic                                moving;
   logic                                step;
   logic [jshs_pkg::PHASE_W-1:0]        phase_step;

   // a zero limit counts as one
   assign limit     = (slowest == '0) ? 9'd1 : slowest;
   assign speed_up1 = {1'b0, speed_ff} + 10'd1;

   // mode machine and speed setting
   always_comb begin
      mode_next  = mode_ff;
      speed_next = speed_ff;
      case (mode_ff)
         jshs_pkg::MODE_INIT: begin
            mode_next = jshs_pkg::MODE_CCW;
         end
         jshs_pkg::MODE_CCW, jshs_pkg::MODE_CW: begin
            if (mode_ff == jshs_pkg::MODE_CCW && status == jshs_pkg::STICK_LEFT) begin
               mode_next = jshs_pkg::MODE_CW;
            end else if (mode_ff == jshs_pkg::MODE_CW && status == jshs_pkg::STICK_RIGHT) begin
               mode_next = jshs_pkg::MODE_CCW;
            end else if (status == jshs_pkg::STICK_UP) begin
               speed_next = (speed_ff > 9'd1) ? speed_ff - 9'd1 : 9'd1;
            end else if (status == jshs_pkg::STICK_DOWN) begin
               speed_next = (speed_up1 < {1'b0, limit}) ? speed_up1[jshs_pkg::SPEED_W-1:0]
                                                       : limit;
            end else if (status == jshs_pkg::STICK_PRESSED) begin
               mode_next = jshs_pkg::MODE_STOP;
            end
         end
         jshs_pkg::MODE_STOP: begin
            if (status != jshs_pkg::STICK_PRESSED) begin
               mode_next = last_cw_ff ? jshs_pkg::MODE_CW : jshs_pkg::MODE_CCW;
            end
         end
         default: begin
            mode_next = jshs_pkg::MODE_INIT;
         end
      endcase
   end

   // step interval from the updated setting
   assign speed_m1      = speed_next - 9'd1;
   assign interval_prod = {21'd0, speed_m1} * {9'd0, jshs_pkg::INTERVAL_MULT};
   assign interval      = (speed_next == '0) ? 6'd1
                        : interval_prod[jshs_pkg::INTERVAL_SHIFT +: jshs_pkg::TICK_W] + 6'd1;

   // saturating tick count, then the step decision
   assign ticks_inc  = (ticks_ff == jshs_pkg::TICK_MAX) ? jshs_pkg::TICK_MAX : ticks_ff + 6'd1;
   assign moving     = (mode_next == jshs_pkg::MODE_CCW) || (mode_next == jshs_pkg::MODE_CW);
   assign step       = moving && (ticks_inc > interval);
   assign phase_step = (mode_next == jshs_pkg::MODE_CW) ? phase_ff + 3'd1 : phase_ff - 3'd1;

   // next state, held unless an item is taken
   always_comb begin
      mode_in    = mode_ff;
      speed_in   = speed_ff;
      phase_in   = phase_ff;
      last_cw_in = last_cw_ff;
      ticks_in   = ticks_ff;
      coil_in    = coil_ff;
      if (advance) begin
         mode_in  = mode_next;
         speed_in = speed_next;
         ticks_in = ticks_inc;
         if (step) begin
            phase_in   = phase_step;
            last_cw_in = (mode_next == jshs_pkg::MODE_CW);
            ticks_in   = '0;
            coil_in    = jshs_pkg::half_step(phase_step);
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= jshs_pkg::MODE_INIT;
         speed_ff   <= 9'd1;
         phase_ff   <= '0;
         last_cw_ff <= 1'b0;
         ticks_ff   <= '0;
         coil_ff    <= '0;
      end else begin
         mode_ff    <= mode_in;
         speed_ff   <= speed_in;
         phase_ff   <= phase_in;
         last_cw_ff <= last_cw_in;
         ticks_ff   <= ticks_in;
         coil_ff    <= coil_in;
      end
   end

   // result of the item being taken
   assign result.coils         = coil_in;
   assign result.stepped       = step;
   assign result.motor_mode    = mode_next;
   assign result.speed_setting = speed_next;
   assign result.stick_status  = status;

endmodule

/* rtl/joystick_stepper_half_step_driver_core.sv */
// top level: input register, classifier, control update and result register
// each item passes the input register, then the result register; a full result stage holds it back
// throughput: one item per cycle, bounded only by rsp_tready; set by the single
//   pass through the classifier and the mode/speed/step update
// reset (synchronous): both stages empty, mode init, setting 1, phase 0,
//   tick count and coils 0, threshold 200, slowest setting 500
module joystick_stepper_half_step_driver_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // input item stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [jshs_pkg::REQ_TDATA_W-1:0]       req_tdata,  // joy_x, joy_y, button_n, pad
   // result item stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // coils, stepped, motor_mode, speed_setting, stick_status, pad
   output logic [jshs_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // register writes
   input  logic                                   csr_we,
   input  logic                                   csr_addr,
   input  logic [jshs_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int unsigned REQ_BITS = $bits(jshs_pkg::req_type);
   localparam int unsigned RSP_BITS = $bits(jshs_pkg::rsp_type);

   logic                         in_valid_ff, in_valid_in;
   jshs_pkg::req_type            in_item_ff, in_item_in;
   logic                         out_valid_ff, out_valid_in;
   jshs_pkg::rsp_type            out_item_ff, out_item_in;
   logic [jshs_pkg::CSR_W-1:0]   threshold_ff, threshold_in;
   logic [jshs_pkg::CSR_W-1:0]   slowest_ff, slowest_in;

   logic                         advance;
   logic                         req_take;
   jshs_pkg::stick_type          status;
   jshs_pkg::rsp_type            result;

   // handshake: the input stage moves on whenever the result stage has room
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // input stage
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = jshs_pkg::req_type'(req_tdata[REQ_BITS-1:0]);
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // result stage
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // configuration registers
   always_comb begin
      threshold_in = threshold_ff;
      slowest_in   = slowest_ff;
      if (csr_we) begin
         case (csr_addr)
            jshs_pkg::CSR_STICK_THRESHOLD: threshold_in = csr_wdata;
            jshs_pkg::CSR_SLOWEST_SETTING: slowest_in   = csr_wdata;
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= jshs_pkg::THRESHOLD_RESET;
         slowest_ff   <= jshs_pkg::SLOWEST_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         threshold_ff <= threshold_in;
         slowest_ff   <= slowest_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   jshs_classify u_classify (
      .item      (in_item_ff),
      .threshold (threshold_ff),
      .status    (status)
   );

   jshs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .status  (status),
      .slowest (slowest_ff),
      .result  (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(jshs_pkg::RSP_TDATA_W - RSP_BITS){1'b0}}, out_item_ff};

endmodule

/* rtl/jshs_checker.sv */
// port-level checks on the driver core, bound to the top level
module jshs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [jshs_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled item holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // the speed setting never reaches zero
   a_speed_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:7] != '0))
      else $error("speed setting is zero");

   // a step happens only while turning
   a_step_moving: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4]) |->
         (rsp_tdata[6:5] == jshs_pkg::MODE_CCW || rsp_tdata[6:5] == jshs_pkg::MODE_CW))
      else $error("step outside a turning mode");

   // after a step some coils are driven
   a_step_coils: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[4]) |-> (rsp_tdata[3:0] != '0))
      else $error("step with no coil driven");

endmodule

bind joystick_stepper_half_step_driver_core jshs_checker u_jshs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/joystick_stepper_half_step_driver_checker.sv */
// channel monitor, drive predictor and result comparison for the stepper driver
`timescale 1ns / 100ps

module joystick_stepper_half_step_driver_checker
   import jshs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // joy_x, joy_y, button_n, pad
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // coils, stepped, motor_mode, speed_setting, stick_status, pad
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic                   csr_addr,
   input  logic [CSR_W-1:0]       csr_wdata,
   output int                     fail_count,
   output int                     outstanding,
   output int                     checked_count
);

   // half-step coil patterns, phase 0 in the lowest nibble
   localparam logic [31:0] COIL_SEQ = 32'h9_8_C_4_6_2_3_1;

   // register copies
   logic [CSR_W-1:0]   thr_reg;
   logic [CSR_W-1:0]   slow_reg;

   // motor state
   mode_type           cur_mode;
   logic [SPEED_W-1:0] cur_speed;
   logic [PHASE_W-1:0] cur_phase;
   logic               went_cw;
   logic [TICK_W-1:0]  tick_count;
   logic [COIL_W-1:0]  cur_coils;

   rsp_type            expected_drive[$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      checked_count = 0;
   end

   // joystick classification, later tests win
   function automatic stick_type read_stick(input logic [JOY_W-1:0] x,
                                            input logic [JOY_W-1:0] y,
                                            input logic btn_n);
      int unsigned t;
      int unsigned hi;
      stick_type   s;
      t  = thr_reg;
      hi = 1000 - t;
      s  = STICK_OFF;
      if (!btn_n) s = STICK_PRESSED;
      if (x <= t) s = STICK_DOWN;
      if (x >= hi) s = STICK_UP;
      if (y <= t) s = STICK_LEFT;
      if (y >= hi) s = STICK_RIGHT;
      return s;
   endfunction

   // one tick of the mode machine, speed control and step timer
   task automatic advance_motor(input req_type item, output rsp_type res);
      stick_type   js;
      int unsigned lim;
      int unsigned bumped;
      int unsigned interval;
      logic        stepped;
      js      = read_stick(item.joy_x, item.joy_y, item.button_n);
      lim     = (slow_reg == 0) ? 1 : slow_reg;
      stepped = 1'b0;
      case (cur_mode)
         MODE_INIT: begin
            cur_mode = MODE_CCW;
         end
         MODE_CCW, MODE_CW: begin
            if (cur_mode == MODE_CCW && js == STICK_LEFT) begin
               cur_mode = MODE_CW;
            end else if (cur_mode == MODE_CW && js == STICK_RIGHT) begin
               cur_mode = MODE_CCW;
            end else if (js == STICK_UP) begin
               cur_speed = (cur_speed > 1) ? cur_speed - 1'b1 : SPEED_W'(1);
            end else if (js == STICK_DOWN) begin
               bumped    = int'(cur_speed) + 1;
               cur_speed = SPEED_W'((bumped < lim) ? bumped : lim);
            end else if (js == STICK_PRESSED) begin
               cur_mode = MODE_STOP;
            end
         end
         default: begin
            if (js != STICK_PRESSED) cur_mode = went_cw ? MODE_CW : MODE_CCW;
         end
      endcase

      // step timer: count first, then compare
      interval = ((int'(cur_speed) - 1) * 39) / 500 + 1;
      if (tick_count < 63) tick_count = tick_count + 1'b1;
      if ((cur_mode == MODE_CCW || cur_mode == MODE_CW) && tick_count > interval) begin
         if (cur_mode == MODE_CCW) begin
            cur_phase = cur_phase - 1'b1;
            went_cw   = 1'b0;
         end else begin
            cur_phase = cur_phase + 1'b1;
            went_cw   = 1'b1;
         end
         cur_coils  = COIL_SEQ[{cur_phase, 2'b00} +: 4];
         tick_count = '0;
         stepped    = 1'b1;
      end

      res.coils         = cur_coils;
      res.stepped       = stepped;
      res.motor_mode    = cur_mode;
      res.speed_setting = cur_speed;
      res.stick_status  = js;
   endtask

   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // watch register writes, accepted ticks and returned drive items
   always @(posedge clock) begin
      rsp_type res;
      rsp_type want;
      rsp_type got;
      if (reset) begin
         thr_reg    = THRESHOLD_RESET;
         slow_reg   = SLOWEST_RESET;
         cur_mode   = MODE_INIT;
         cur_speed  = SPEED_W'(1);
         cur_phase  = '0;
         went_cw    = 1'b0;
         tick_count = '0;
         cur_coils  = '0;
         expected_drive.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_STICK_THRESHOLD) thr_reg = csr_wdata;
            else if (csr_addr == CSR_SLOWEST_SETTING) slow_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            advance_motor(req_type'(req_tdata[$bits(req_type)-1:0]), res);
            expected_drive.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (expected_drive.size() == 0) begin
               $error("drive item with no tick pending: 0x%0h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_drive.pop_front();
               compare_field("coils", want.coils, got.coils);
               compare_field("stepped", want.stepped, got.stepped);
               compare_field("motor_mode", want.motor_mode, got.motor_mode);
               compare_field("speed_setting", want.speed_setting, got.speed_setting);
               compare_field("stick_status", want.stick_status, got.stick_status);
               checked_count++;
            end
         end
      end
      outstanding <= expected_drive.size();
   end

endmodule

/* test/joystick_stepper_half_step_driver_core_tb.sv */
// stimulus, flow control and verdict for the joystick stepper half-step driver
`timescale 1ns / 100ps

module joystick_stepper_half_step_driver_core_tb;
   import jshs_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // joy_x, joy_y, button_n, pad
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // coils, stepped, motor_mode, speed_setting, stick_status, pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic                   csr_addr;
   logic [CSR_W-1:0]       csr_wdata;

   int fail_count;
   int outstanding;
   int checked_count;
   int ticks_sent       = 0;
   int settings_applied = 0;
   int drives_taken     = 0;
   int quiet_cycles     = 0;

   joystick_stepper_half_step_driver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   joystick_stepper_half_step_driver_checker drive_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hang detection: no item moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, stall-free stretches and one long hold
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (drives_taken == 200) stall = 80;
         else if ((drives_taken / 32) % 4 == 3) stall = 0;
         else stall = $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         drives_taken++;
      end
   end

   // offer one tick item after an optional gap, return once accepted
   task automatic send_tick(input logic [JOY_W-1:0] x, input logic [JOY_W-1:0] y,
                            input logic btn_n, input logic burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_W'({btn_n, y, x});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // stop offering and wait for every pending drive item plus the pipeline depth
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [CSR_W-1:0] thr, input logic [CSR_W-1:0] slow);
      drain_results();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_STICK_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      csr_addr  <= CSR_SLOWEST_SETTING;
      csr_wdata <= slow;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_applied++;
   endtask

   // reading right at or next to a deflection boundary
   function automatic logic [JOY_W-1:0] near_threshold(input int unsigned thr);
      case ($urandom_range(0, 3))
         0:       return JOY_W'(thr);
         1:       return JOY_W'(thr + 1);
         2:       return JOY_W'(999 - thr);
         default: return JOY_W'(1000 - thr);
      endcase
   endfunction

   // mostly well-formed stick gestures, some boundary and raw noise
   task automatic random_tick(input int unsigned thr, input logic burst);
      int unsigned    pick;
      int unsigned    hi;
      logic [JOY_W-1:0] x;
      logic [JOY_W-1:0] y;
      logic           b;
      hi   = 1000 - thr;
      x    = (thr < 499) ? JOY_W'($urandom_range(thr + 1, 999 - thr)) : JOY_W'(500);
      y    = (thr < 499) ? JOY_W'($urandom_range(thr + 1, 999 - thr)) : JOY_W'(500);
      b    = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         b = 1'b1;
      end else if (pick < 24) begin
         b = 1'b0;
      end else if (pick < 40) begin
         x = JOY_W'($urandom_range(hi, 1023));
         b = 1'($urandom_range(0, 1));
      end else if (pick < 56) begin
         x = JOY_W'($urandom_range(0, thr));
         b = 1'($urandom_range(0, 1));
      end else if (pick < 66) begin
         y = JOY_W'($urandom_range(0, thr));
         b = 1'($urandom_range(0, 1));
      end else if (pick < 76) begin
         y = JOY_W'($urandom_range(hi, 1023));
         b = 1'($urandom_range(0, 1));
      end else if (pick < 86) begin
         x = near_threshold(thr);
         y = near_threshold(thr);
         b = 1'($urandom_range(0, 1));
      end else begin
         x = JOY_W'($urandom_range(0, 1023));
         y = JOY_W'($urandom_range(0, 1023));
         b = 1'($urandom_range(0, 1));
      end
      send_tick(x, y, b, burst);
   endtask

   initial begin
      logic [CSR_W-1:0] thr;
      logic [CSR_W-1:0] slow;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_STICK_THRESHOLD;
      csr_wdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: leaving init, direction swaps, speed floor, stop and resume
      send_tick(10'd500, 10'd0, 1'b1, 1'b0);
      send_tick(10'd0, 10'd0, 1'b1, 1'b0);
      send_tick(10'd500, 10'd1023, 1'b1, 1'b0);
      send_tick(10'd1023, 10'd500, 1'b1, 1'b0);
      send_tick(10'd0, 10'd500, 1'b1, 1'b0);
      send_tick(10'd0, 10'd500, 1'b1, 1'b0);
      send_tick(10'd0, 10'd500, 1'b1, 1'b0);
      send_tick(10'd500, 10'd500, 1'b0, 1'b0);
      send_tick(10'd1023, 10'd500, 1'b0, 1'b0);
      send_tick(10'd500, 10'd500, 1'b0, 1'b0);
      send_tick(10'd500, 10'd500, 1'b0, 1'b0);
      send_tick(10'd500, 10'd500, 1'b1, 1'b0);

      // setting above a lowered limit, then a zero limit
      apply_setting(THRESHOLD_RESET, 9'd2);
      send_tick(10'd1023, 10'd500, 1'b1, 1'b0);
      send_tick(10'd0, 10'd500, 1'b1, 1'b0);
      apply_setting(THRESHOLD_RESET, 9'd0);
      send_tick(10'd0, 10'd500, 1'b1, 1'b0);
      send_tick(10'd0, 10'd500, 1'b1, 1'b0);

      // threshold extremes, overlapping deflection zones at the top one
      apply_setting(9'd0, SLOWEST_RESET);
      send_tick(10'd0, 10'd500, 1'b1, 1'b0);
      send_tick(10'd1000, 10'd999, 1'b1, 1'b0);
      send_tick(10'd999, 10'd1, 1'b1, 1'b0);
      apply_setting(9'd511, SLOWEST_RESET);
      send_tick(10'd500, 10'd600, 1'b1, 1'b0);
      send_tick(10'd1023, 10'd1023, 1'b0, 1'b0);

      // long slow-down ramp toward the widest setting
      apply_setting(THRESHOLD_RESET, 9'd511);
      for (int i = 0; i < 200; i++) begin
         if ($urandom_range(0, 19) != 0) begin
            send_tick(JOY_W'($urandom_range(0, 200)), JOY_W'($urandom_range(201, 799)),
                      1'($urandom_range(0, 1)), (i / 40) % 3 == 2);
         end else begin
            send_tick(JOY_W'($urandom_range(0, 1023)), JOY_W'($urandom_range(0, 1023)),
                      1'($urandom_range(0, 1)), 1'b0);
         end
      end

      // random phases over a spread of register settings
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            1:       thr = 9'd0;
            2:       thr = 9'd511;
            3:       thr = CSR_W'($urandom_range(1, 510));
            default: thr = THRESHOLD_RESET;
         endcase
         case (p)
            1:       slow = 9'd0;
            2:       slow = 9'd1;
            3:       slow = 9'd511;
            4:       slow = CSR_W'($urandom_range(2, 40));
            5:       slow = CSR_W'($urandom_range(1, 511));
            6:       slow = CSR_W'($urandom_range(2, 20));
            default: slow = SLOWEST_RESET;
         endcase
         apply_setting(thr, slow);
         for (int i = 0; i < 28; i++) begin
            if (p == 4 && i == 14) drain_results();
            random_tick(thr, (i / 7) % 3 == 2);
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      $display("covered %0d joystick ticks under %0d register settings: directed cases,",
               ticks_sent, settings_applied);
      $display("a slow-down ramp and random gestures; %0d drive items compared",
               checked_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
